@@ src/efd_pkg.sv @@
// shared types, constants and crc step for the escaped frame deframer
`default_nettype none

package efd_pkg;

	localparam int HDR_BYTES = 6;
	localparam int CRC_BYTES = 2;
	localparam int FRAME_OVERHEAD = HDR_BYTES + CRC_BYTES;
	localparam int PLEN_W = 6;
	localparam int LEN_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK = 2'd2;

	localparam logic [7:0] DELIMITER_RESET = 8'h7e;
	localparam logic [7:0] ESCAPE_RESET = 8'h7d;
	localparam logic [7:0] MASK_RESET = 8'h20;

	localparam logic [15:0] CRC_INIT = 16'hffff;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_MSB = 16'h8000;

	typedef struct packed {
		logic accept;
		logic load_hdr;
		logic rd_issue;
		logic load_data;
	} cmd_t;

	typedef struct packed {
		logic close;
		logic fail;
		logic plen_zero;
		logic last_byte;
		logic out_free;
	} sts_t;

	// crc-16/ccitt-false, one byte msb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
		logic [15:0] c;
		c = crc_in ^ {d, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ src/efd_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module efd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 40
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/efd_ctrl.sv @@
// controller state machine: input acceptance and report sequencing
`default_nettype none

module efd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire efd_pkg::sts_t sts,
	output efd_pkg::cmd_t      cmd
);

	import efd_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HDR = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_DATA = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.accept = in_valid;
				if (sts.close) begin
					state_d = S_HDR;
				end
			end
			S_HDR: begin
				if (sts.out_free) begin
					cmd.load_hdr = 1'b1;
					state_d = (sts.fail || sts.plen_zero) ? S_IDLE : S_READ;
				end
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
				state_d = S_DATA;
			end
			S_DATA: begin
				if (sts.out_free) begin
					cmd.load_data = 1'b1;
					state_d = sts.last_byte ? S_IDLE : S_READ;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_close_to_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		sts.close |=> (state_q == S_HDR) && in_stall)
		else $error("closing delimiter did not start a report");
	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_hdr || cmd.load_data) |-> sts.out_free)
		else $error("output register overwritten");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.accept)
		else $error("transaction taken during report");
`endif

endmodule

`default_nettype wire

@@ src/efd_datapath.sv @@
// datapath: unstuffing, body store, crc, checks and output register
`default_nettype none

module efd_datapath #(
	parameter int MAX_PAYLOAD = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire efd_pkg::cmd_t                   cmd,
	output efd_pkg::sts_t                        sts,
	input  wire logic                            wr_en,
	input  wire logic [efd_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [7:0]                      wr_data,
	input  wire logic [7:0]                      rx_byte,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 is_header,
	output logic                                 is_error,
	output logic [7:0]                           version,
	output logic [7:0]                           frame_flags,
	output logic [7:0]                           frame_type,
	output logic [7:0]                           sequence_res,
	output logic [efd_pkg::PLEN_W-1:0]           payload_len,
	output logic [7:0]                           data_byte,
	output logic                                 last
);

	import efd_pkg::*;

	localparam int BODY_CAP = FRAME_OVERHEAD + MAX_PAYLOAD;
	localparam int CW = $clog2(BODY_CAP + 1);
	localparam int AW = $clog2(BODY_CAP);

	logic [7:0] delim_q;
	logic [7:0] esc_q;
	logic [7:0] mask_q;

	logic          in_frame_q;
	logic          esc_pend_q;
	logic          ovf_q;
	logic [CW-1:0] byte_cnt_q;
	logic [15:0]   crc_q;
	logic [7:0]    p1_q;
	logic [7:0]    p2_q;
	logic [7:0]    hdr_q [HDR_BYTES];

	logic              fail_q;
	logic [PLEN_W-1:0] plen_q;
	logic [PLEN_W-1:0] ptr_q;

	logic              out_valid_q;
	logic              is_header_q;
	logic              is_error_q;
	logic [7:0]        version_q;
	logic [7:0]        flags_q;
	logic [7:0]        type_q;
	logic [7:0]        seq_q;
	logic [PLEN_W-1:0] plen_out_q;
	logic [7:0]        data_q;
	logic              last_q;

	logic             is_delim;
	logic             is_esc;
	logic             store_en;
	logic             full;
	logic             ram_we;
	logic [7:0]       body_byte;
	logic             close;
	logic [LEN_W-1:0] len16;
	logic             fail;
	logic [AW-1:0]    rd_addr;
	logic [7:0]       rd_data;

	assign is_delim = rx_byte == delim_q;
	assign is_esc = rx_byte == esc_q;
	assign body_byte = esc_pend_q ? (rx_byte ^ mask_q) : rx_byte;
	assign store_en = cmd.accept && !is_delim && in_frame_q && !ovf_q
		&& (esc_pend_q || !is_esc);
	assign full = byte_cnt_q >= CW'(BODY_CAP);
	assign ram_we = store_en && !full;
	assign close = cmd.accept && is_delim && in_frame_q && ((byte_cnt_q != '0) || ovf_q);

	assign len16 = {hdr_q[5], hdr_q[4]};
	assign fail = esc_pend_q || ovf_q
		|| (byte_cnt_q < CW'(FRAME_OVERHEAD))
		|| (len16 > LEN_W'(MAX_PAYLOAD))
		|| ((17'(byte_cnt_q)) != ({1'b0, len16} + 17'(FRAME_OVERHEAD)))
		|| (crc_q != {p1_q, p2_q});

	assign rd_addr = AW'(HDR_BYTES + int'(ptr_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIMITER_RESET;
			esc_q <= ESCAPE_RESET;
			mask_q <= MASK_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DELIMITER: delim_q <= wr_data;
				REG_ESCAPE: esc_q <= wr_data;
				REG_MASK: mask_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_pend_q <= 1'b0;
			ovf_q <= 1'b0;
			byte_cnt_q <= '0;
			crc_q <= CRC_INIT;
		end else if (cmd.accept) begin
			if (is_delim) begin
				in_frame_q <= 1'b1;
				esc_pend_q <= 1'b0;
				ovf_q <= 1'b0;
				byte_cnt_q <= '0;
				crc_q <= CRC_INIT;
			end else if (in_frame_q && !ovf_q) begin
				if (esc_pend_q) begin
					esc_pend_q <= 1'b0;
				end else if (is_esc) begin
					esc_pend_q <= 1'b1;
				end
				if (store_en) begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						byte_cnt_q <= byte_cnt_q + CW'(1);
						if (byte_cnt_q >= CW'(2)) begin
							crc_q <= crc_byte(crc_q, p2_q);
						end
					end
				end
			end
		end
	end

	// last two body bytes trail the crc, header bytes kept for the report
	always_ff @(posedge clk) begin
		if (ram_we) begin
			p1_q <= body_byte;
			p2_q <= p1_q;
			for (int i = 0; i < HDR_BYTES; i++) begin
				if (byte_cnt_q == CW'(i)) begin
					hdr_q[i] <= body_byte;
				end
			end
		end
		if (close) begin
			fail_q <= fail;
			plen_q <= len16[PLEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.load_hdr) begin
			ptr_q <= '0;
		end else if (cmd.load_data) begin
			ptr_q <= ptr_q + PLEN_W'(1);
		end
	end

	efd_ram #(
		.WIDTH(8),
		.DEPTH(BODY_CAP)
	) u_body_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(byte_cnt_q[AW-1:0]),
		.wdata(body_byte),
		.re   (cmd.rd_issue),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_comb begin
		sts.close = close;
		sts.fail = fail_q;
		sts.plen_zero = plen_q == '0;
		sts.last_byte = ({1'b0, ptr_q} + 7'd1) == {1'b0, plen_q};
		sts.out_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_hdr || cmd.load_data) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_hdr) begin
			is_header_q <= 1'b1;
			is_error_q <= fail_q;
			version_q <= fail_q ? 8'h00 : hdr_q[0];
			flags_q <= fail_q ? 8'h00 : hdr_q[1];
			type_q <= fail_q ? 8'h00 : hdr_q[2];
			seq_q <= fail_q ? 8'h00 : hdr_q[3];
			plen_out_q <= fail_q ? '0 : plen_q;
			data_q <= 8'h00;
			last_q <= fail_q || (plen_q == '0);
		end else if (cmd.load_data) begin
			is_header_q <= 1'b0;
			is_error_q <= 1'b0;
			version_q <= 8'h00;
			flags_q <= 8'h00;
			type_q <= 8'h00;
			seq_q <= 8'h00;
			plen_out_q <= '0;
			data_q <= rd_data;
			last_q <= sts.last_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign is_header = is_header_q;
	assign is_error = is_error_q;
	assign version = version_q;
	assign frame_flags = flags_q;
	assign frame_type = type_q;
	assign sequence_res = seq_q;
	assign payload_len = plen_out_q;
	assign data_byte = data_q;
	assign last = last_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_cnt_q <= CW'(BODY_CAP))
		else $error("body count past capacity");
	a_ovf_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> (byte_cnt_q == CW'(BODY_CAP)))
		else $error("overflow flagged below capacity");
	a_data_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_data |-> (!fail_q && (ptr_q < plen_q)))
		else $error("payload read outside frame");
`endif

endmodule

`default_nettype wire

@@ src/escaped_frame_deframer_crc16_unit.sv @@
// top level of the byte stuffed frame deframer with crc-16 check
//
//  channel   signals                                 dir  transaction
//  rx        in_valid / in_stall, rx_byte            in   in_valid & !in_stall
//  report    out_valid / out_stall, result fields    out  out_valid & !out_stall
//  config    wr_en, wr_index, wr_data                in   wr_en
//
//  a received byte is taken with in_valid while no report is running
//  a closing delimiter starts a report: header or error item once the output is free,
//  then each payload byte is read from the registered body ram and loaded in turn
//  rx is stalled after the closing delimiter until the last report item is loaded
//  out_stall holds the output register; reset clears all control state
`default_nettype none

module escaped_frame_deframer_crc16_unit #(
	parameter int MAX_PAYLOAD = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    rx_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               is_header,
	output logic                               is_error,
	output logic [7:0]                         version,
	output logic [7:0]                         frame_flags,
	output logic [7:0]                         frame_type,
	output logic [7:0]                         sequence_res,
	output logic [efd_pkg::PLEN_W-1:0]         payload_len,
	output logic [7:0]                         data_byte,
	output logic                               last,
	input  wire logic                          wr_en,
	input  wire logic [efd_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [7:0]                    wr_data
);

	import efd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	efd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	efd_datapath #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_header   (is_header),
		.is_error    (is_error),
		.version     (version),
		.frame_flags (frame_flags),
		.frame_type  (frame_type),
		.sequence_res(sequence_res),
		.payload_len (payload_len),
		.data_byte   (data_byte),
		.last        (last)
	);

endmodule

`default_nettype wire
